[hw/rtl/mprt_pkg.sv]
// ----------------------------------------------------------------------------
// mprt_pkg
// Shared types and constants for the MAC PDU reassembly tracker.
// ----------------------------------------------------------------------------
package mprt_pkg;

    // Width of the accumulated SDU length register
    localparam int SDU_LEN_BITS = 16;

    // Width of the SDU length result port
    localparam int SDU_OUT_BITS = 16;

    // Largest value the accumulated length can hold
    localparam logic [SDU_LEN_BITS-1:0] SDU_LEN_MAX = '1;

    // Fixed MAC header size and subheader sizes in bytes
    localparam logic [3:0] OH_GENERIC_HDR   = 4'd6;
    localparam logic [3:0] OH_MESH          = 4'd2;
    localparam logic [3:0] OH_GRANT         = 4'd2;
    localparam logic [3:0] OH_FRAG_BASIC    = 4'd1;
    localparam logic [3:0] OH_FRAG_EXT      = 4'd2;
    localparam logic [3:0] OH_PACK_BASIC    = 4'd2;
    localparam logic [3:0] OH_PACK_EXT      = 4'd3;

    // Bit positions inside the header type field
    localparam int TY_GRANT = 0;
    localparam int TY_PACK  = 1;
    localparam int TY_FRAG  = 2;
    localparam int TY_EXT   = 3;
    localparam int TY_ARQ   = 4;
    localparam int TY_MESH  = 5;

    // Command codes
    typedef enum logic {
        CMD_PDU   = 1'b0,
        CMD_FETCH = 1'b1
    } t_cmd;

    // Fragment control codes
    typedef enum logic [1:0] {
        FC_UNFRAG = 2'd0,
        FC_LAST   = 2'd1,
        FC_FIRST  = 2'd2,
        FC_MIDDLE = 2'd3
    } t_frag_ctrl;

    // Reassembly phase, encoded as reported on the result port
    typedef enum logic [1:0] {
        PH_NONE     = 2'd0,
        PH_PARTIAL  = 2'd1,
        PH_COMPLETE = 2'd2,
        PH_EXTERNAL = 2'd3
    } t_phase;

endpackage

[hw/rtl/mac_pdu_reassembly_tracker_unit.sv]
// ----------------------------------------------------------------------------
// mac_pdu_reassembly_tracker_unit
// Tracks 802.16-style MAC fragment reassembly by length for PDU descriptors.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one transaction per PDU
//   descriptor or fetch command. Output channel (o_out_valid / i_out_stall)
//   returns exactly one result transaction per input transaction, in order.
//   A transaction is taken at a rising edge where valid is high and stall low.
// Pipeline and throughput:
//   An accepted transaction sits in the input register; its result is
//   computed from it and the tracker state and lands in the result
//   register, from which it is offered on the output channel.
//   One transaction per cycle is sustained while i_out_stall is low; the
//   state update (overhead sum, length subtract, saturating add) is a
//   single pass between the two registers.
// Reset:
//   i_rst_n low clears both pipeline valids, the phase to no data, the
//   accumulated length and the last fragment sequence number to zero.
// Stall:
//   While i_out_stall holds a valid result, a transaction waiting in the
//   input register raises o_in_stall; with the input register empty one more
//   transaction is still taken.
// ----------------------------------------------------------------------------
module mac_pdu_reassembly_tracker_unit
    import mprt_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // Input channel
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic                    i_cmd,
    input  logic [5:0]              i_type_bits,
    input  logic [1:0]              i_frag_control,
    input  logic [2:0]              i_frag_seq,
    input  logic [10:0]             i_pdu_len,
    // Output channel
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [1:0]              o_phase,
    output logic [SDU_OUT_BITS-1:0] o_sdu_len,
    output logic                    o_sdu_ready,
    output logic [3:0]              o_payload_offset,
    output logic                    o_partial_dropped,
    output logic                    o_seq_error,
    output logic                    o_malformed,
    output logic                    o_overflow
);

    // Pipeline control
    logic r_in_vld;
    logic r_out_vld;
    logic w_adv;
    logic w_in_take;
    logic w_fire;

    // Input register
    logic        r_in_cmd;
    logic [5:0]  r_in_type;
    logic [1:0]  r_in_fc;
    logic [2:0]  r_in_seq;
    logic [10:0] r_in_len;

    // Tracker state
    t_phase                  r_phase,    n_phase;
    logic [SDU_LEN_BITS-1:0] r_acc_len,  n_acc_len;
    logic [2:0]              r_last_seq, n_last_seq;

    // Result register
    t_phase                  r_out_phase,   n_out_phase;
    logic [SDU_OUT_BITS-1:0] r_out_len,     n_out_len;
    logic                    r_out_ready,   n_out_ready;
    logic [3:0]              r_out_oh,      n_out_oh;
    logic                    r_out_dropped, n_out_dropped;
    logic                    r_out_serr,    n_out_serr;
    logic                    r_out_bad,     n_out_bad;
    logic                    r_out_ovf,     n_out_ovf;

    // Datapath intermediates
    logic                    w_ext_sub;
    logic [3:0]              w_oh;
    logic [10:0]             w_pay;
    logic [SDU_LEN_BITS:0]   w_sum;

    // Handshake: result register frees up when empty or taken
    assign w_adv      = !r_out_vld || !i_out_stall;
    assign o_in_stall = r_in_vld && !w_adv;
    assign w_in_take  = i_in_valid && !o_in_stall;
    assign w_fire     = r_in_vld && w_adv;

    // Input register and pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_in_take) begin
                r_in_vld <= 1'b1;
            end else if (w_fire) begin
                r_in_vld <= 1'b0;
            end
            if (w_adv) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_cmd  <= i_cmd;
            r_in_type <= i_type_bits;
            r_in_fc   <= i_frag_control;
            r_in_seq  <= i_frag_seq;
            r_in_len  <= i_pdu_len;
        end
    end

    // Header and subheader overhead
    always_comb begin
        w_ext_sub = r_in_type[TY_EXT] || r_in_type[TY_ARQ];
        w_oh      = OH_GENERIC_HDR;
        if (r_in_type[TY_MESH]) begin
            w_oh = w_oh + OH_MESH;
        end
        if (r_in_type[TY_GRANT]) begin
            w_oh = w_oh + OH_GRANT;
        end
        if (r_in_type[TY_FRAG]) begin
            w_oh = w_oh + (w_ext_sub ? OH_FRAG_EXT : OH_FRAG_BASIC);
        end
        if (r_in_type[TY_PACK]) begin
            w_oh = w_oh + (w_ext_sub ? OH_PACK_EXT : OH_PACK_BASIC);
        end
        w_pay = r_in_len - 11'(w_oh);
        w_sum = {1'b0, r_acc_len} + (SDU_LEN_BITS + 1)'(w_pay);
    end

    // Reassembly state update and result
    always_comb begin
        n_phase       = r_phase;
        n_acc_len     = r_acc_len;
        n_last_seq    = r_last_seq;
        n_out_ready   = 1'b0;
        n_out_oh      = 4'd0;
        n_out_dropped = 1'b0;
        n_out_serr    = 1'b0;
        n_out_bad     = 1'b0;
        n_out_ovf     = 1'b0;
        n_out_len     = SDU_OUT_BITS'(r_acc_len);

        unique case (t_cmd'(r_in_cmd))
            CMD_FETCH: begin
                if (r_phase == PH_COMPLETE || r_phase == PH_EXTERNAL) begin
                    n_out_ready = 1'b1;
                    n_phase     = PH_NONE;
                    n_acc_len   = '0;
                end
            end
            CMD_PDU: begin
                n_out_oh = w_oh;
                if (r_in_len < 11'(w_oh)) begin
                    n_out_bad = 1'b1;
                end else if (r_in_type[TY_FRAG]) begin
                    // Basic fragments: sequence check, gap drops held data
                    if (!w_ext_sub) begin
                        if (r_in_seq != r_last_seq + 3'd1) begin
                            n_out_serr    = 1'b1;
                            n_out_dropped = (r_phase != PH_NONE);
                            n_phase       = PH_NONE;
                            n_acc_len     = '0;
                        end
                        n_last_seq = r_in_seq;
                    end
                    unique case (t_frag_ctrl'(r_in_fc))
                        FC_UNFRAG, FC_FIRST: begin
                            n_out_dropped = n_out_dropped || (n_phase != PH_NONE);
                            n_acc_len     = SDU_LEN_BITS'(w_pay);
                            n_phase       = (t_frag_ctrl'(r_in_fc) == FC_UNFRAG)
                                            ? PH_COMPLETE : PH_PARTIAL;
                        end
                        FC_LAST, FC_MIDDLE: begin
                            if (n_phase == PH_PARTIAL) begin
                                if (w_sum[SDU_LEN_BITS]) begin
                                    n_acc_len = SDU_LEN_MAX;
                                    n_out_ovf = 1'b1;
                                end else begin
                                    n_acc_len = w_sum[SDU_LEN_BITS-1:0];
                                end
                                n_phase = (t_frag_ctrl'(r_in_fc) == FC_LAST)
                                          ? PH_COMPLETE : PH_PARTIAL;
                            end
                        end
                        default: begin
                            n_phase = n_phase;
                        end
                    endcase
                end else begin
                    // No fragment subheader: replaces whatever is held
                    n_out_dropped = (r_phase != PH_NONE);
                    n_acc_len     = SDU_LEN_BITS'(w_pay);
                    n_phase       = PH_EXTERNAL;
                end
                n_out_len = SDU_OUT_BITS'(n_acc_len);
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
        n_out_phase = n_phase;
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_NONE;
            r_acc_len  <= '0;
            r_last_seq <= 3'd0;
        end else if (w_fire) begin
            r_phase    <= n_phase;
            r_acc_len  <= n_acc_len;
            r_last_seq <= n_last_seq;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_phase   <= n_out_phase;
            r_out_len     <= n_out_len;
            r_out_ready   <= n_out_ready;
            r_out_oh      <= n_out_oh;
            r_out_dropped <= n_out_dropped;
            r_out_serr    <= n_out_serr;
            r_out_bad     <= n_out_bad;
            r_out_ovf     <= n_out_ovf;
        end
    end

    assign o_out_valid       = r_out_vld;
    assign o_phase           = r_out_phase;
    assign o_sdu_len         = r_out_len;
    assign o_sdu_ready       = r_out_ready;
    assign o_payload_offset  = r_out_oh;
    assign o_partial_dropped = r_out_dropped;
    assign o_seq_error       = r_out_serr;
    assign o_malformed       = r_out_bad;
    assign o_overflow        = r_out_ovf;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // Empty phase never holds a length
    a_none_zero_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_NONE |-> r_acc_len == '0)
        else $error("no-data phase with nonzero accumulated length");

    // A fetch hand-out leaves no data and carries no overhead or flags
    a_fetch_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_sdu_ready |-> o_phase == PH_NONE && o_payload_offset == 4'd0
            && !o_partial_dropped && !o_seq_error && !o_malformed && !o_overflow)
        else $error("fetch result with stray phase, offset or flags");

    // A malformed PDU raises no other flag
    a_bad_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_malformed |-> !o_partial_dropped && !o_seq_error
            && !o_overflow && !o_sdu_ready)
        else $error("malformed PDU raised another flag");

    // Saturation reports the clamped maximum in a fragmented phase
    a_ovf_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_overflow |-> o_sdu_len == SDU_OUT_BITS'(SDU_LEN_MAX)
            && (o_phase == PH_PARTIAL || o_phase == PH_COMPLETE))
        else $error("overflow without clamped length");

    // Tracker state holds while the receiver stalls a valid result
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && r_out_vld && i_out_stall |=> $stable(r_phase) && $stable(r_acc_len))
        else $error("tracker state moved while the result path was blocked");

endmodule

[sim/tb_mac_pdu_reassembly_tracker_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mac_pdu_reassembly_tracker_unit
// Checks the MAC PDU reassembly tracker against a cycle-free predictor of the
// phase, SDU length, overhead and flags. A directed run walks the fragment
// rules, then random fragment sequences, fetches and noise follow, with random
// idling on both channels and one long hold-off on the result side.
// ----------------------------------------------------------------------------
module tb_mac_pdu_reassembly_tracker_unit;
    import mprt_pkg::*;

    // One input transaction
    typedef struct packed {
        t_cmd       cmd;
        logic [5:0] type_bits;
        t_frag_ctrl frag_ctrl;
        logic [2:0] frag_seq;
        logic [10:0] pdu_len;
    } t_pdu_item;

    // One result transaction
    typedef struct packed {
        t_phase                  phase;
        logic [SDU_OUT_BITS-1:0] sdu_len;
        logic                    sdu_ready;
        logic [3:0]              payload_offset;
        logic                    partial_dropped;
        logic                    seq_error;
        logic                    malformed;
        logic                    overflow;
    } t_track_result;

    // Clock, reset and block ports
    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_stall;
    logic                    i_cmd = 1'b0;
    logic [5:0]              i_type_bits = '0;
    logic [1:0]              i_frag_control = '0;
    logic [2:0]              i_frag_seq = '0;
    logic [10:0]             i_pdu_len = '0;
    logic                    o_out_valid;
    logic                    i_out_stall = 1'b0;
    logic [1:0]              o_phase;
    logic [SDU_OUT_BITS-1:0] o_sdu_len;
    logic                    o_sdu_ready;
    logic [3:0]              o_payload_offset;
    logic                    o_partial_dropped;
    logic                    o_seq_error;
    logic                    o_malformed;
    logic                    o_overflow;

    // Stimulus and expectation stores
    t_pdu_item     pending_pdus[$];
    t_track_result awaited_results[$];
    t_pdu_item     drv_item;

    // Tracker state as predicted
    t_phase                  trk_phase = PH_NONE;
    logic [SDU_LEN_BITS-1:0] trk_len = '0;
    logic [2:0]              trk_last_seq = '0;

    // Handshake and idling bookkeeping
    logic in_taken = 1'b0;
    logic jitter_on = 1'b0;
    logic long_hold = 1'b0;
    int   src_idle = 0;
    int   sink_idle = 0;
    int   accepted_cnt = 0;
    int   result_cnt = 0;
    int   fail_cnt = 0;
    int   cycle_cnt = 0;
    logic jitter_mode = 1'b1;

    mac_pdu_reassembly_tracker_unit i_dut (.*);

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Print one mismatch line and count it
    task automatic report_mismatch(input string msg);
        fail_cnt++;
        $display("ERROR result %0d: %s", result_cnt, msg);
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    // Drop held data; returns 1 if something was held
    function automatic logic drop_held();
        if (trk_phase != PH_NONE) begin
            trk_phase = PH_NONE;
            trk_len   = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Predict the result of one transaction and advance the tracker state
    function automatic t_track_result track_pdu(input t_pdu_item it);
        t_track_result         r;
        logic                  ext_sub;
        logic [3:0]            oh;
        logic [10:0]           pay;
        logic [2:0]            next_seq;
        logic [SDU_LEN_BITS:0] sum;
        r = '0;
        ext_sub = it.type_bits[TY_EXT] | it.type_bits[TY_ARQ];
        if (it.cmd == CMD_FETCH) begin
            r.sdu_len = SDU_OUT_BITS'(trk_len);
            if (trk_phase == PH_COMPLETE || trk_phase == PH_EXTERNAL) begin
                r.sdu_ready = 1'b1;
                trk_phase   = PH_NONE;
                trk_len     = '0;
            end
        end else begin
            // header plus subheader overhead
            oh = OH_GENERIC_HDR;
            if (it.type_bits[TY_MESH])  oh = oh + OH_MESH;
            if (it.type_bits[TY_GRANT]) oh = oh + OH_GRANT;
            if (it.type_bits[TY_FRAG])  oh = oh + (ext_sub ? OH_FRAG_EXT : OH_FRAG_BASIC);
            if (it.type_bits[TY_PACK])  oh = oh + (ext_sub ? OH_PACK_EXT : OH_PACK_BASIC);
            r.payload_offset = oh;
            if (it.pdu_len < {7'd0, oh}) begin
                r.malformed = 1'b1;
            end else begin
                pay = it.pdu_len - {7'd0, oh};
                if (it.type_bits[TY_FRAG]) begin
                    // basic fragments carry a checked 3-bit sequence
                    if (!ext_sub) begin
                        next_seq = trk_last_seq + 3'd1;
                        if (it.frag_seq != next_seq) begin
                            r.seq_error = 1'b1;
                            r.partial_dropped = drop_held();
                        end
                        trk_last_seq = it.frag_seq;
                    end
                    case (it.frag_ctrl)
                        FC_UNFRAG: begin
                            r.partial_dropped = drop_held() | r.partial_dropped;
                            trk_len   = SDU_LEN_BITS'(pay);
                            trk_phase = PH_COMPLETE;
                        end
                        FC_FIRST: begin
                            r.partial_dropped = drop_held() | r.partial_dropped;
                            trk_len   = SDU_LEN_BITS'(pay);
                            trk_phase = PH_PARTIAL;
                        end
                        default: begin
                            // middle or last only extend a partial SDU
                            if (trk_phase == PH_PARTIAL) begin
                                sum = {1'b0, trk_len} + (SDU_LEN_BITS+1)'(pay);
                                if (sum > {1'b0, SDU_LEN_MAX}) begin
                                    sum = {1'b0, SDU_LEN_MAX};
                                    r.overflow = 1'b1;
                                end
                                trk_len   = sum[SDU_LEN_BITS-1:0];
                                trk_phase = (it.frag_ctrl == FC_LAST) ? PH_COMPLETE
                                                                      : PH_PARTIAL;
                            end
                        end
                    endcase
                end else begin
                    r.partial_dropped = (trk_phase != PH_NONE);
                    trk_len   = SDU_LEN_BITS'(pay);
                    trk_phase = PH_EXTERNAL;
                end
            end
            r.sdu_len = SDU_OUT_BITS'(trk_len);
        end
        r.phase = trk_phase;
        return r;
    endfunction

    task automatic queue_item(input t_cmd cmd, input logic [5:0] ty, input t_frag_ctrl fc,
                              input logic [2:0] seq, input logic [10:0] len);
        t_pdu_item it;
        it.cmd       = cmd;
        it.type_bits = ty;
        it.frag_ctrl = fc;
        it.frag_seq  = seq;
        it.pdu_len   = len;
        pending_pdus.insert(pending_pdus.size(), it);
    endtask

    task automatic queue_fetch();
        queue_item(CMD_FETCH, 6'($urandom), t_frag_ctrl'($urandom_range(0, 3)),
                   3'($urandom), 11'($urandom));
    endtask

    // Build the stimulus, run reset, wait for the drain and judge
    initial begin
        logic [2:0]  gen_seq;
        logic [5:0]  ty;
        logic [10:0] len;
        t_frag_ctrl  fc;
        int          kind;
        int          n_mid;
        int          bad_at;
        logic        broken;
        logic        big;

        // directed: fetch rules, overhead extremes, sequence and phase cases
        queue_item(CMD_FETCH, 6'h00, FC_UNFRAG, 3'd0, 11'd0);
        queue_item(CMD_PDU,   6'h00, FC_MIDDLE, 3'd7, 11'd6);
        queue_item(CMD_FETCH, 6'h00, FC_UNFRAG, 3'd0, 11'd0);
        queue_item(CMD_FETCH, 6'h3F, FC_MIDDLE, 3'd7, 11'h7FF);
        queue_item(CMD_PDU,   6'h3F, FC_FIRST,  3'd0, 11'd14);
        queue_item(CMD_PDU,   6'h3F, FC_FIRST,  3'd0, 11'h7FF);
        queue_item(CMD_PDU,   6'h00, FC_UNFRAG, 3'd0, 11'h7FF);
        queue_item(CMD_PDU,   6'h04, FC_LAST,   3'd1, 11'd100);
        queue_item(CMD_PDU,   6'h04, FC_FIRST,  3'd2, 11'd7);
        queue_item(CMD_PDU,   6'h04, FC_MIDDLE, 3'd3, 11'h7FF);
        queue_item(CMD_FETCH, 6'h00, FC_UNFRAG, 3'd0, 11'd0);
        queue_item(CMD_PDU,   6'h04, FC_MIDDLE, 3'd5, 11'd50);
        queue_item(CMD_PDU,   6'h04, FC_LAST,   3'd6, 11'd50);
        queue_item(CMD_PDU,   6'h06, FC_FIRST,  3'd7, 11'd10);
        queue_item(CMD_PDU,   6'h27, FC_MIDDLE, 3'd0, 11'd14);
        queue_item(CMD_PDU,   6'h05, FC_LAST,   3'd1, 11'd9);
        queue_item(CMD_PDU,   6'h04, FC_UNFRAG, 3'd2, 11'd20);
        queue_item(CMD_FETCH, 6'h00, FC_UNFRAG, 3'd0, 11'd0);
        queue_item(CMD_PDU,   6'h04, FC_UNFRAG, 3'd3, 11'd6);
        queue_item(CMD_PDU,   6'h04, FC_UNFRAG, 3'd3, 11'd7);
        queue_item(CMD_PDU,   6'h21, FC_UNFRAG, 3'd0, 11'd9);
        queue_item(CMD_PDU,   6'h21, FC_UNFRAG, 3'd0, 11'd10);
        queue_item(CMD_PDU,   6'h14, FC_MIDDLE, 3'd7, 11'h7FF);
        queue_item(CMD_PDU,   6'h0C, FC_FIRST,  3'd0, 11'd8);
        queue_item(CMD_PDU,   6'h1E, FC_LAST,   3'd4, 11'd20);
        queue_item(CMD_FETCH, 6'h00, FC_UNFRAG, 3'd0, 11'd0);
        gen_seq = 3'd3;

        // random part, mostly well-formed fragment sequences
        while (pending_pdus.size() < 1426) begin
            kind = $urandom_range(0, 99);
            if (kind < 55) begin
                // basic fragments: first, middles, last; some long enough to saturate
                big    = ($urandom_range(0, 24) == 0);
                n_mid  = big ? $urandom_range(34, 42) : $urandom_range(0, 5);
                broken = ($urandom_range(0, 9) == 0);
                bad_at = ($urandom_range(0, 4) == 0) ? $urandom_range(0, n_mid + 1) : -1;
                for (int k = 0; k <= n_mid + 1; k++) begin
                    if (broken && k == n_mid + 1)
                        break;
                    ty  = (6'($urandom) & 6'b100111) | 6'b000100;
                    fc  = (k == 0) ? FC_FIRST : (k == n_mid + 1) ? FC_LAST : FC_MIDDLE;
                    gen_seq = (k == bad_at) ? 3'($urandom) : gen_seq + 3'd1;
                    len = big ? 11'($urandom_range(1900, 2047)) : 11'($urandom_range(15, 2047));
                    queue_item(CMD_PDU, ty, fc, gen_seq, len);
                end
                if ($urandom_range(0, 4) != 0)
                    queue_fetch();
            end else if (kind < 63) begin
                // basic fragment subheader on an unfragmented SDU
                ty = (6'($urandom) & 6'b100111) | 6'b000100;
                gen_seq = ($urandom_range(0, 5) == 0) ? 3'($urandom) : gen_seq + 3'd1;
                queue_item(CMD_PDU, ty, FC_UNFRAG, gen_seq, 11'($urandom_range(15, 2047)));
                if ($urandom_range(0, 1) != 0)
                    queue_fetch();
            end else if (kind < 73) begin
                // ARQ or extended fragments, sequence not checked
                n_mid = $urandom_range(0, 2);
                for (int k = 0; k <= n_mid + 1; k++) begin
                    ty = 6'($urandom) | 6'b000100;
                    if (!(ty[TY_EXT] | ty[TY_ARQ]))
                        ty[TY_ARQ] = 1'b1;
                    fc = (k == 0) ? FC_FIRST : (k == n_mid + 1) ? FC_LAST : FC_MIDDLE;
                    queue_item(CMD_PDU, ty, fc, 3'($urandom), 11'($urandom_range(15, 2047)));
                end
                queue_fetch();
            end else if (kind < 83) begin
                // PDU without fragment subheader
                ty = 6'($urandom) & 6'b111011;
                queue_item(CMD_PDU, ty, t_frag_ctrl'($urandom_range(0, 3)), 3'($urandom),
                           11'($urandom));
                if ($urandom_range(0, 1) != 0)
                    queue_fetch();
            end else if (kind < 89) begin
                queue_fetch();
            end else begin
                // noise, often short enough to be malformed
                ty  = 6'($urandom);
                len = ($urandom_range(0, 1) != 0) ? 11'($urandom_range(0, 24)) : 11'($urandom);
                queue_item(t_cmd'($urandom_range(0, 1)), ty,
                           t_frag_ctrl'($urandom_range(0, 3)), 3'($urandom), len);
                if (ty[TY_FRAG] && !(ty[TY_EXT] | ty[TY_ARQ]))
                    gen_seq = pending_pdus[$].frag_seq;
            end
        end

        // reset
        repeat (9) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // drain
        while (pending_pdus.size() != 0 || i_in_valid)
            @(posedge i_clk);
        while (awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_cnt == 0 && awaited_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Long receiver hold-off so the block fills and stalls its input
    initial begin
        while (accepted_cnt < 400)
            @(posedge i_clk);
        long_hold = 1'b1;
        repeat (80) @(posedge i_clk);
        long_hold = 1'b0;
    end

    // Run limit
    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // Monitor: capture accepted transactions, predict, check results
    always @(posedge i_clk) begin
        t_track_result want;
        cycle_cnt++;
        if (cycle_cnt % 200 == 0)
            jitter_mode = ($urandom_range(0, 2) != 0);
        jitter_on = jitter_mode && (pending_pdus.size() > 150);

        in_taken = i_rst_n && i_in_valid && !o_in_stall;
        if (in_taken) begin
            awaited_results.insert(awaited_results.size(), track_pdu(drv_item));
            accepted_cnt++;
        end

        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (awaited_results.size() == 0) begin
                report_mismatch("result with no transaction waiting");
            end else begin
                want = awaited_results[0];
                awaited_results.delete(0);
                check_field("phase", o_phase, want.phase);
                check_field("sdu_len", o_sdu_len, want.sdu_len);
                check_field("sdu_ready", o_sdu_ready, want.sdu_ready);
                check_field("payload_offset", o_payload_offset, want.payload_offset);
                check_field("partial_dropped", o_partial_dropped, want.partial_dropped);
                check_field("seq_error", o_seq_error, want.seq_error);
                check_field("malformed", o_malformed, want.malformed);
                check_field("overflow", o_overflow, want.overflow);
            end
            result_cnt++;
        end
    end

    // Driver: offer the next transaction once the current one is taken
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_taken)) begin
            if (src_idle > 0) begin
                src_idle--;
                i_in_valid <= 1'b0;
            end else if (in_taken && jitter_on && $urandom_range(0, 5) == 0) begin
                src_idle = $urandom_range(0, 14);
                i_in_valid <= 1'b0;
            end else if (pending_pdus.size() != 0) begin
                drv_item = pending_pdus[0];
                pending_pdus.delete(0);
                i_cmd          <= drv_item.cmd;
                i_type_bits    <= drv_item.type_bits;
                i_frag_control <= drv_item.frag_ctrl;
                i_frag_seq     <= drv_item.frag_seq;
                i_pdu_len      <= drv_item.pdu_len;
                i_in_valid     <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result-side stall: random bursts plus the long hold-off
    always @(negedge i_clk) begin
        if (sink_idle > 0) begin
            sink_idle--;
            i_out_stall <= 1'b1;
        end else if (long_hold) begin
            i_out_stall <= 1'b1;
        end else if (jitter_on && $urandom_range(0, 7) == 0) begin
            sink_idle = $urandom_range(0, 14);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

endmodule
